[hdl/mcr_pkg.sv]
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies; used by mcr_ctrl, mcr_datapath and the top level.
`default_nettype none

package mcr_pkg;

   localparam int NUM_SLOTS = 8;
   localparam int SLOT_BITS = 3;

   // request action codes
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_STEP = 1'b1;

   typedef logic [SLOT_BITS-1:0] slot_type;
   typedef logic [NUM_SLOTS-1:0] slot_mask_type;

   // controller -> datapath
   typedef struct packed {
      logic     load;     // latch center, start a new outline
      logic     capture;  // latch next octant point for this step
      logic     emit;     // drive one pixel word from slot
      slot_type slot;     // bit 2: swapped set, bit 1: negate b, bit 0: negate a
      logic     last;     // final pixel of this step
      logic     commit;   // move next point into current point
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic          x_lt_y;     // current point already past the octant
      logic          done;       // captured step finishes the circle
      slot_mask_type slot_mask;  // mirrors present for the current point
   } dp_status_type;

endpackage

`default_nettype wire

[hdl/mcr_ctrl.sv]
// Sequencer for the midpoint circle rasterizer: handshake, circle-active
// flag and per-step pixel slot walk. Depends on mcr_pkg.
`default_nettype none

module mcr_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   action,
   output logic                        busy,
   input  wire mcr_pkg::dp_status_type status,
   output mcr_pkg::dp_cmd_type         cmd
);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_EMIT = 1'b1;

   logic [0:0]                 state_ff, state_in;
   logic                       active_ff, active_in;
   mcr_pkg::slot_mask_type     pend_ff, pend_in;
   mcr_pkg::slot_type          low_slot;
   logic                       accept;

   assign busy   = (state_ff == ST_EMIT);
   assign accept = start && !busy;

   // lowest pending slot
   always_comb begin
      low_slot = '0;
      for (int i = mcr_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (pend_ff[i]) low_slot = mcr_pkg::slot_type'(i);
      end
   end

   always_comb begin
      state_in    = state_ff;
      active_in   = active_ff;
      pend_in     = pend_ff;
      cmd         = '0;
      cmd.slot    = low_slot;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (action == mcr_pkg::ACTION_LOAD) begin
                  cmd.load  = 1'b1;
                  active_in = 1'b1;
               end else if (active_ff) begin
                  if (status.x_lt_y) begin
                     active_in = 1'b0;
                  end else begin
                     cmd.capture = 1'b1;
                     pend_in     = status.slot_mask;
                     state_in    = ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            pend_in  = pend_ff & ~(mcr_pkg::slot_mask_type'(1) << low_slot);
            if (pend_in == '0) begin
               cmd.last   = 1'b1;
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
               if (status.done) active_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= 1'b0;
         pend_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

`default_nettype wire

[hdl/mcr_datapath.sv]
// Datapath for the midpoint circle rasterizer: center, octant point,
// decision error, next-point update and mirrored pixel output. Depends on mcr_pkg.
`default_nettype none

module mcr_datapath #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mcr_pkg::dp_cmd_type         cmd,
   input  wire logic [COORD_BITS-1:0]       req_center_x,
   input  wire logic [COORD_BITS-1:0]       req_center_y,
   input  wire logic [COORD_BITS-1:0]       req_radius,
   output mcr_pkg::dp_status_type           status,
   output logic                             rsp_strobe,
   output logic signed [COORD_BITS+1:0]     rsp_pixel_x,
   output logic signed [COORD_BITS+1:0]     rsp_pixel_y,
   output logic                             rsp_last_of_step,
   output logic                             rsp_circle_done
);

   localparam int OFS_W  = COORD_BITS + 1;
   localparam int ERR_W  = COORD_BITS + 2;
   localparam int PIX_W  = COORD_BITS + 2;
   localparam int CALC_W = ERR_W + 2;

   logic [COORD_BITS-1:0]     center_col_ff, center_row_ff;
   logic signed [OFS_W-1:0]   ofs_x_ff, ofs_y_ff, nxt_x_ff, nxt_y_ff;
   logic signed [ERR_W-1:0]   err_ff, nxt_err_ff;
   logic                      nxt_done_ff;

   logic                      strobe_ff;
   logic [PIX_W-1:0]          pix_x_ff, pix_y_ff;
   logic                      last_ff, done_out_ff;

   // next-point arithmetic
   logic signed [CALC_W-1:0]  e_ext, y_dbl, x_dbl, e_up, e_diag;
   logic signed [OFS_W-1:0]   nx, ny;
   logic signed [ERR_W-1:0]   ne;
   logic                      x_nz, y_nz, x_ne_y;

   // pixel selection
   logic [OFS_W-1:0]          a_sel, b_sel;
   logic [PIX_W-1:0]          a_ext, b_ext, cx_ext, cy_ext, px, py;

   always_comb begin
      e_ext  = {{(CALC_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
      y_dbl  = {{(CALC_W-OFS_W-1){ofs_y_ff[OFS_W-1]}}, ofs_y_ff, 1'b0};
      x_dbl  = {{(CALC_W-OFS_W-1){ofs_x_ff[OFS_W-1]}}, ofs_x_ff, 1'b0};
      e_up   = e_ext + y_dbl + CALC_W'(1);
      e_diag = e_ext + y_dbl - x_dbl + CALC_W'(2);
      ny     = ofs_y_ff + OFS_W'(1);
      if (!e_up[CALC_W-1]) begin
         nx = ofs_x_ff - OFS_W'(1);
         ne = e_diag[ERR_W-1:0];
      end else begin
         nx = ofs_x_ff;
         ne = e_up[ERR_W-1:0];
      end
   end

   assign x_nz   = (ofs_x_ff != '0);
   assign y_nz   = (ofs_y_ff != '0);
   assign x_ne_y = (ofs_x_ff != ofs_y_ff);

   always_comb begin
      status.x_lt_y       = (ofs_x_ff < ofs_y_ff);
      status.done         = nxt_done_ff;
      status.slot_mask[0] = 1'b1;
      status.slot_mask[1] = x_nz;
      status.slot_mask[2] = y_nz;
      status.slot_mask[3] = x_nz && y_nz;
      status.slot_mask[4] = x_ne_y;
      status.slot_mask[5] = x_ne_y && y_nz;
      status.slot_mask[6] = x_ne_y && x_nz;
      status.slot_mask[7] = x_ne_y && x_nz && y_nz;
   end

   // slot bit 2 swaps the roles of x and y
   always_comb begin
      a_sel  = cmd.slot[2] ? ofs_y_ff : ofs_x_ff;
      b_sel  = cmd.slot[2] ? ofs_x_ff : ofs_y_ff;
      a_ext  = {a_sel[OFS_W-1], a_sel};
      b_ext  = {b_sel[OFS_W-1], b_sel};
      cx_ext = {2'b00, center_col_ff};
      cy_ext = {2'b00, center_row_ff};
      px     = cmd.slot[0] ? (cx_ext - a_ext) : (cx_ext + a_ext);
      py     = cmd.slot[1] ? (cy_ext - b_ext) : (cy_ext + b_ext);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         center_col_ff <= req_center_x;
         center_row_ff <= req_center_y;
         ofs_x_ff      <= {1'b0, req_radius};
         ofs_y_ff      <= '0;
         err_ff        <= ERR_W'(0) - {2'b00, req_radius};
      end else if (cmd.commit) begin
         ofs_x_ff      <= nxt_x_ff;
         ofs_y_ff      <= nxt_y_ff;
         err_ff        <= nxt_err_ff;
      end
      if (cmd.capture) begin
         nxt_x_ff    <= nx;
         nxt_y_ff    <= ny;
         nxt_err_ff  <= ne;
         nxt_done_ff <= (nx < ny);
      end
      if (cmd.emit) begin
         pix_x_ff    <= px;
         pix_y_ff    <= py;
         last_ff     <= cmd.last;
         done_out_ff <= nxt_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_pixel_x      = pix_x_ff;
   assign rsp_pixel_y      = pix_y_ff;
   assign rsp_last_of_step = last_ff;
   assign rsp_circle_done  = done_out_ff;

endmodule

`default_nettype wire

[hdl/midpoint_circle_rasterizer_top.sv]
// Top level of the midpoint circle rasterizer.
// Instantiates mcr_ctrl and mcr_datapath; depends on mcr_pkg.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ---------------------------
//   request   req_action, req_center_x/y, req_radius  taken when start && !busy
//   response  rsp_pixel_x/y, rsp_last_of_step,        one word per rsp_strobe cycle
//             rsp_circle_done
//
// A load word emits nothing. A step word holds busy while it emits the pixels
// it produces (1 to 8, one pixel per cycle through the output register); each
// pixel word shows up in the cycle after its emit cycle. A step on an idle
// circle, or past the octant, emits nothing.
// Reset is synchronous and clears the sequencer, the circle-active flag and
// the response strobe. The receiver cannot stall: every strobed word is taken.
`default_nettype none

module midpoint_circle_rasterizer_top #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic                     req_action,
   input  wire logic [COORD_BITS-1:0]    req_center_x,
   input  wire logic [COORD_BITS-1:0]    req_center_y,
   input  wire logic [COORD_BITS-1:0]    req_radius,
   output logic                          rsp_strobe,
   output logic signed [COORD_BITS+1:0]  rsp_pixel_x,
   output logic signed [COORD_BITS+1:0]  rsp_pixel_y,
   output logic                          rsp_last_of_step,
   output logic                          rsp_circle_done
);

   mcr_pkg::dp_cmd_type    dp_cmd;
   mcr_pkg::dp_status_type dp_status;

   // sequencer: accepts words, tracks the active circle, walks mirror slots
   mcr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_action),
      .busy   (busy),
      .status (dp_status),
      .cmd    (dp_cmd)
   );

   // datapath: point state, midpoint update, pixel output register
   mcr_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius       (req_radius),
      .status           (dp_status),
      .rsp_strobe       (rsp_strobe),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_circle_done  (rsp_circle_done)
   );

endmodule

`default_nettype wire
